// ===== design/sync_length_frame_deframer_core_assert.svh =====
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core_assert.svh
// Assertion macros used by the deframer parser.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define SLFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/slfd_pkg.sv =====
// ----------------------------------------------------------------------------
// slfd_pkg
// Types and constants of the sync/length frame deframer.
// ----------------------------------------------------------------------------
package slfd_pkg;

  localparam logic       CMD_BYTE       = 1'b0;
  localparam logic       CMD_TICK       = 1'b1;
  localparam logic       KIND_PAYLOAD   = 1'b0;
  localparam logic       KIND_VERDICT   = 1'b1;
  localparam logic [7:0] SYNC_FIRST     = 8'h41;
  localparam logic [7:0] SYNC_SECOND    = 8'h54;
  localparam logic [15:0] SUM_SEED      = 16'hAB34;
  localparam logic [7:0] TIMEOUT_RESET  = 8'd10;
  localparam logic [7:0] IDLE_MAX       = 8'hFF;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CSUM_HI = 3'd5,
    PH_CSUM_LO = 3'd6
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       checksum_ok;
  } result_t;

endpackage

// ===== design/slfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// slfd_in_reg
// Input register: captures one beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module slfd_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  slfd_pkg::item_t item,
  input  logic           advance,
  output logic           held_valid,
  output slfd_pkg::item_t held
);
  import slfd_pkg::*;

  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

endmodule

// ===== design/slfd_parser.sv =====
// ----------------------------------------------------------------------------
// slfd_parser
// Frame state machine, running checksum, idle timeout and result forming.
// ----------------------------------------------------------------------------
module slfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  logic             held_valid,
  input  slfd_pkg::item_t  held,
  input  logic             advance,
  output logic             res_valid,
  output slfd_pkg::result_t res
);
  import slfd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  timeout_ticks;
  logic [7:0]  command_byte, command_byte_next;
  logic [7:0]  length_byte, length_byte_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  checksum_high, checksum_high_next;
  logic [7:0]  idle_count, idle_count_next;
  logic [7:0]  idle_inc;
  logic [7:0]  position_inc;
  logic        take;
  logic        is_byte;

  assign take         = held_valid && advance;
  assign is_byte      = (held.cmd == CMD_BYTE);
  assign idle_inc     = (idle_count == IDLE_MAX) ? idle_count : idle_count + 8'd1;
  assign position_inc = byte_position + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      command_byte  <= 8'd0;
      length_byte   <= 8'd0;
      byte_position <= 8'd0;
      running_sum   <= SUM_SEED;
      checksum_high <= 8'd0;
      idle_count    <= 8'd0;
    end else begin
      phase         <= phase_next;
      command_byte  <= command_byte_next;
      length_byte   <= length_byte_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      checksum_high <= checksum_high_next;
      idle_count    <= idle_count_next;
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    command_byte_next  = command_byte;
    length_byte_next   = length_byte;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    checksum_high_next = checksum_high;
    idle_count_next    = idle_count;
    if (take && !is_byte) begin
      idle_count_next = idle_inc;
      if (phase != PH_HUNT && idle_inc >= timeout_ticks) begin
        phase_next = PH_HUNT;
      end
    end else if (take) begin
      idle_count_next = 8'd0;
      unique case (phase)
        PH_SYNC2: begin
          phase_next = (held.rx_byte == SYNC_SECOND) ? PH_CMD : PH_HUNT;
        end
        PH_CMD: begin
          command_byte_next = held.rx_byte;
          running_sum_next  = SUM_SEED + {8'd0, held.rx_byte};
          phase_next        = PH_LEN;
        end
        PH_LEN: begin
          length_byte_next   = held.rx_byte;
          running_sum_next   = running_sum + {8'd0, held.rx_byte};
          byte_position_next = 8'd0;
          phase_next         = (held.rx_byte == 8'd0) ? PH_CSUM_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_sum_next   = running_sum + {8'd0, held.rx_byte};
          byte_position_next = position_inc;
          if (position_inc == length_byte) begin
            phase_next = PH_CSUM_HI;
          end
        end
        PH_CSUM_HI: begin
          checksum_high_next = held.rx_byte;
          phase_next         = PH_CSUM_LO;
        end
        PH_CSUM_LO: begin
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = (held.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.frame_command = command_byte;
    res.frame_length  = length_byte;
    res.checksum_ok   = 1'b0;
    if (held_valid && is_byte) begin
      unique case (phase)
        PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.payload_byte  = held.rx_byte;
          res.payload_index = byte_position;
        end
        PH_CSUM_LO: begin
          res_valid       = 1'b1;
          res.kind        = KIND_VERDICT;
          res.checksum_ok = ({checksum_high, held.rx_byte} == running_sum);
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

`include "sync_length_frame_deframer_core_assert.svh"

  `SLFD_ASSERT_NOW(a_verdict_phase, clk, rst, res_valid && res.kind == KIND_VERDICT, phase == PH_CSUM_LO, "verdict outside checksum low phase")
  `SLFD_ASSERT_NOW(a_index_in_frame, clk, rst, res_valid && res.kind == KIND_PAYLOAD, res.payload_index < length_byte, "payload index beyond frame length")
  `SLFD_ASSERT_NEXT(a_timeout_drop, clk, rst, take && !is_byte && phase != PH_HUNT && idle_inc >= timeout_ticks, phase == PH_HUNT, "timeout did not drop frame")

endmodule

// ===== design/slfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// slfd_out_reg
// Result register: holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module slfd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  slfd_pkg::result_t res,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output slfd_pkg::result_t result
);
  import slfd_pkg::*;

  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      result <= res;
    end
  end

endmodule

// ===== design/sync_length_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core
// Sync/length frame deframer with additive 16-bit checksum.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+-----------------------------
//   item     | item_valid / item_stall    | cmd, rx_byte
//   result   | result_valid / result_stall| payload byte or verdict
//   config   | cfg_we                     | cfg_data (timeout ticks)
//
// One item per cycle unless stalled; a result beat is valid in the cycle after
// its item is taken, set by the result register behind the combinational parser.
// Synchronous reset clears the frame state; timeout resets to 10 ticks.
// A stalled result holds the pipeline; item_stall rises only while the input
// register is full and the result register cannot move.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  slfd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output slfd_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);
  import slfd_pkg::*;

  logic    advance;
  logic    held_valid;
  item_t   held;
  logic    res_valid;
  result_t res;

  slfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  slfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held       (held),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  slfd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
